>>> src/dbcs_pkg.sv
// Shared types, constants and helpers for the DRAM bank command scheduler.
package dbcs_pkg;

  localparam int BANK_GROUPS     = 4;
  localparam int BANKS_PER_GROUP = 4;
  localparam int QUEUE_DEPTH     = 16;
  localparam int NBANKS          = BANK_GROUPS * BANKS_PER_GROUP;
  localparam int BANK_W          = $clog2(NBANKS);
  localparam int QIDX_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
  localparam int BUS_W           = 4;

  // Fixed DRAM timings, counted in ticks
  localparam logic [7:0] T_RRD_L = 8'd6;
  localparam logic [7:0] T_RRD_S = 8'd4;
  localparam logic [7:0] T_WR    = 8'd20;
  localparam logic [7:0] T_WTR_L = 8'd12;
  localparam logic [7:0] T_WTR_S = 8'd4;
  localparam logic [7:0] T_RTP   = 8'd12;
  localparam logic [7:0] SAT     = 8'd255;

  typedef enum logic [2:0] {
    CMD_NONE = 3'd0,
    CMD_ACT  = 3'd1,
    CMD_PRE  = 3'd2,
    CMD_RD   = 3'd3,
    CMD_WR   = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    BS_PRE        = 4'd0,
    BS_PRE_WAIT   = 4'd1,
    BS_PRECHARGED = 4'd2,
    BS_ACT        = 4'd3,
    BS_ACT_WAIT   = 4'd4,
    BS_ACTIVATED  = 4'd5,
    BS_RD         = 4'd6,
    BS_RD_WAIT    = 4'd7,
    BS_WR         = 4'd8,
    BS_WR_WAIT    = 4'd9,
    BS_BURST      = 4'd10
  } bank_st_t;

  typedef enum logic [2:0] {
    REG_BANK_PARALLEL = 3'd0,
    REG_T_RCD         = 3'd1,
    REG_T_RP          = 3'd2,
    REG_T_CAS         = 3'd3,
    REG_T_CWD         = 3'd4,
    REG_T_BURST       = 3'd5,
    REG_T_CCD_LONG    = 3'd6,
    REG_T_CCD_SHORT   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic       bank_parallel;
    logic [5:0] t_rcd;
    logic [5:0] t_rp;
    logic [5:0] t_cas;
    logic [5:0] t_cwd;
    logic [3:0] t_burst;
    logic [5:0] t_ccd_long;
    logic [5:0] t_ccd_short;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  bg;
    logic [1:0]  bk;
    logic [15:0] row;
    logic [9:0]  col;
    logic        wr;
    logic        busy;
  } qent_t;

  typedef struct packed {
    logic              enq;
    logic              set_busy;
    logic              rem;
    logic [QIDX_W-1:0] idx;
    qent_t             enq_ent;
  } q_ctl_t;

  typedef struct packed {
    bank_st_t    st;
    logic [5:0]  timer;
    logic        ov;
    logic [15:0] orow;
  } bank_a_t;

  localparam bank_a_t BANK_A_RESET = '{st: BS_PRECHARGED, timer: 6'd0, ov: 1'b0, orow: 16'd0};

  typedef struct packed {
    cmd_t        cmd;
    logic [1:0]  bg;
    logic [1:0]  bk;
    logic [15:0] rc;
    logic        acc;
    logic        full;
    logic        settled;
  } res_t;

  // A timing written as zero behaves as one
  function automatic logic [5:0] eff6(input logic [5:0] v);
    return (v == 6'd0) ? 6'd1 : v;
  endfunction

  function automatic logic [3:0] eff4(input logic [3:0] v);
    return (v == 4'd0) ? 4'd1 : v;
  endfunction

  function automatic logic [BANK_W-1:0] bank_idx(input logic [1:0] bg, input logic [1:0] bk);
    return BANK_W'(int'(bg) * BANKS_PER_GROUP + int'(bk));
  endfunction

endpackage

>>> src/dbcs_cfg.sv
// APB register file holding the scheduler timing and mode registers.
module dbcs_cfg import dbcs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic     wr_en;
  reg_idx_t ridx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign ridx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bank_parallel <= 1'b0;
      cfg.t_rcd         <= 6'd24;
      cfg.t_rp          <= 6'd24;
      cfg.t_cas         <= 6'd24;
      cfg.t_cwd         <= 6'd20;
      cfg.t_burst       <= 4'd4;
      cfg.t_ccd_long    <= 6'd8;
      cfg.t_ccd_short   <= 6'd4;
    end else if (wr_en) begin
      case (ridx)
        REG_BANK_PARALLEL: cfg.bank_parallel <= pwdata[0];
        REG_T_RCD:         cfg.t_rcd         <= pwdata[5:0];
        REG_T_RP:          cfg.t_rp          <= pwdata[5:0];
        REG_T_CAS:         cfg.t_cas         <= pwdata[5:0];
        REG_T_CWD:         cfg.t_cwd         <= pwdata[5:0];
        REG_T_BURST:       cfg.t_burst       <= pwdata[3:0];
        REG_T_CCD_LONG:    cfg.t_ccd_long    <= pwdata[5:0];
        REG_T_CCD_SHORT:   cfg.t_ccd_short   <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_BANK_PARALLEL: prdata = {31'd0, cfg.bank_parallel};
      REG_T_RCD:         prdata = {26'd0, cfg.t_rcd};
      REG_T_RP:          prdata = {26'd0, cfg.t_rp};
      REG_T_CAS:         prdata = {26'd0, cfg.t_cas};
      REG_T_CWD:         prdata = {26'd0, cfg.t_cwd};
      REG_T_BURST:       prdata = {28'd0, cfg.t_burst};
      REG_T_CCD_LONG:    prdata = {26'd0, cfg.t_ccd_long};
      REG_T_CCD_SHORT:   prdata = {26'd0, cfg.t_ccd_short};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

>>> src/dbcs_queue.sv
// Request queue: append at the tail, mark busy, remove at any place with shift.
module dbcs_queue import dbcs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  q_ctl_t            ctl,
  output qent_t             rd_ent,
  output logic [QCNT_W-1:0] count
);

  qent_t q [QUEUE_DEPTH];

  assign rd_ent = q[ctl.idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.enq) begin
      count <= count + QCNT_W'(1);
    end else if (ctl.rem) begin
      count <= count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.enq) begin
      q[count[QIDX_W-1:0]] <= ctl.enq_ent;
    end else if (ctl.set_busy) begin
      q[ctl.idx].busy <= 1'b1;
    end else if (ctl.rem) begin
      // close the gap: every entry from the removed place on moves down one
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        if (QIDX_W'(i) >= ctl.idx) q[i] <= q[i + 1];
      end
    end
  end

endmodule

>>> src/dbcs_engine.sv
// Enqueue and tick sequencer: bank record memories, trigger, per-bank step and queue release.
module dbcs_engine import dbcs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              start,
  input  logic              op,
  input  qent_t             item,
  output logic              idle,
  output q_ctl_t            qctl,
  input  qent_t             q_ent,
  input  logic [QCNT_W-1:0] q_count,
  input  logic              res_ready,
  output logic              res_valid,
  output res_t              res
);

  typedef enum logic [2:0] {
    E_IDLE, E_TRIG, E_KADDR, E_KUPD, E_SADDR, E_SUPD, E_REL, E_FIN
  } estate_t;

  estate_t           state;
  logic [QCNT_W-1:0] scan;
  logic [1:0]        step_bg, step_bk;

  // bank records: state/timer/open row, and pending row and column
  bank_a_t     mem_a   [NBANKS];
  logic [15:0] mem_row [NBANKS];
  logic [9:0]  mem_col [NBANKS];
  logic [NBANKS-1:0] a_valid, row_valid, col_valid, busy_vec, unsettled;

  logic [BANK_W-1:0] raddr, cur_bank, wb_addr, e_bank, step_bank;
  bank_a_t     rd_a, ra, wa;
  logic [15:0] rd_row, rrow, wrow;
  logic [9:0]  rd_col, rcol, wcol;
  logic        rd_av, rd_rv, rd_cv;
  logic        we_a, we_row, we_col;

  logic [7:0]       since_act [BANK_GROUPS];
  logic [7:0]       since_rd  [BANK_GROUPS];
  logic [7:0]       since_wr  [BANK_GROUPS];
  logic [7:0]       since_bwr [BANKS_PER_GROUP];
  logic [7:0]       since_act_next [BANK_GROUPS];
  logic [7:0]       since_rd_next  [BANK_GROUPS];
  logic [7:0]       since_wr_next  [BANK_GROUPS];
  logic [7:0]       since_bwr_next [BANKS_PER_GROUP];
  cmd_t             last_cmd;
  logic [1:0]       last_act_bg, last_rd_bg, last_wr_bg, last_wr_bk;
  logic [BUS_W-1:0] bus, bus_next;

  logic       rel_pend;
  logic [1:0] rel_bg, rel_bk;
  cmd_t       r_cmd;
  logic [1:0] r_bg, r_bk;
  logic [15:0] r_rc;
  logic       r_acc;

  logic        scan_in, enq_ok, last_bank;
  logic [5:0]  cwd, cas, ccdl, ccds;
  logic [3:0]  bur;
  logic [5:0]  td;
  logic [7:0]  sa, sr, sw, sb;
  logic [8:0]  wr_lat;
  logic        pre_block, act_block, rd_block, wr_block;
  cmd_t        iss;
  logic [15:0] iss_rc;
  logic        burst_go, burst_end;

  assign idle      = (state == E_IDLE);
  assign scan_in   = (scan < q_count);
  assign e_bank    = bank_idx(q_ent.bg, q_ent.bk);
  assign step_bank = bank_idx(step_bg, step_bk);
  assign raddr     = (state == E_SADDR) ? step_bank : e_bank;
  assign wb_addr   = (state == E_TRIG) ? e_bank : cur_bank;
  assign last_bank = (step_bg == 2'(BANK_GROUPS - 1)) && (step_bk == 2'(BANKS_PER_GROUP - 1));
  assign enq_ok    = (q_count < QCNT_W'(QUEUE_DEPTH)) && (int'(item.bg) < BANK_GROUPS) &&
                     (int'(item.bk) < BANKS_PER_GROUP);

  assign ra   = rd_av ? rd_a : BANK_A_RESET;
  assign rrow = rd_rv ? rd_row : 16'd0;
  assign rcol = rd_cv ? rd_col : 10'd0;

  assign cwd  = eff6(cfg.t_cwd);
  assign cas  = eff6(cfg.t_cas);
  assign ccdl = eff6(cfg.t_ccd_long);
  assign ccds = eff6(cfg.t_ccd_short);
  assign bur  = eff4(cfg.t_burst);
  assign td   = (ra.timer != 6'd0) ? ra.timer - 6'd1 : ra.timer;

  assign sa = since_act[last_act_bg];
  assign sr = since_rd[last_rd_bg];
  assign sw = since_wr[last_wr_bg];
  assign sb = since_bwr[last_wr_bk];
  assign wr_lat = 9'(cwd) + 9'(bur) - 9'd1;

  assign pre_block = ((last_cmd == CMD_RD) && (sr < T_RTP)) ||
                     ((last_cmd == CMD_WR) && (last_wr_bk == step_bk) &&
                      (last_wr_bg == step_bg) && (9'(sb) <= wr_lat + 9'(T_WR)));
  assign act_block = (last_act_bg == step_bg) ? (sa < T_RRD_L) : (sa < T_RRD_S);

  always_comb begin
    rd_block = 1'b0;
    wr_block = 1'b0;
    if (last_cmd == CMD_RD) begin
      rd_block = (last_rd_bg == step_bg) ? (sr < 8'(ccdl)) : (sr < 8'(ccds));
      wr_block = (9'(sr) + 9'(cwd)) < (9'(cas) + 9'(bur) + 9'd2);
    end else if (last_cmd == CMD_WR) begin
      rd_block = (last_wr_bg == step_bg) ? (9'(sw) <= wr_lat + 9'(T_WTR_L)) :
                                           (9'(sw) <= wr_lat + 9'(T_WTR_S));
      wr_block = (last_wr_bg == step_bg) ? (sw < 8'(ccdl)) : (sw < 8'(ccds));
    end
  end

  // Record update for the trigger, kick and bank-step phases
  always_comb begin
    wa        = ra;
    we_a      = 1'b0;
    we_row    = 1'b0;
    we_col    = 1'b0;
    wrow      = q_ent.row;
    wcol      = q_ent.col;
    iss       = CMD_NONE;
    iss_rc    = 16'd0;
    burst_go  = 1'b0;
    burst_end = 1'b0;
    case (state)
      E_TRIG: begin
        if (qctl.set_busy) begin
          we_row = 1'b1;
          we_col = 1'b1;
        end
      end
      E_KUPD: begin
        we_a = 1'b1;
        if (ra.st == BS_ACTIVATED || ra.st == BS_PRECHARGED) begin
          if (ra.ov && q_ent.row == ra.orow) begin
            wa.st  = q_ent.wr ? BS_WR : BS_RD;
            we_col = !cfg.bank_parallel;
          end else if (!ra.ov) begin
            wa.st  = BS_ACT;
            we_row = !cfg.bank_parallel;
          end else begin
            wa.st = BS_PRE;
          end
        end
      end
      E_SUPD: begin
        we_a     = 1'b1;
        wa.timer = td;
        case (ra.st)
          BS_PRE: begin
            if (!pre_block && bus == '0) begin
              iss      = CMD_PRE;
              wa.timer = eff6(cfg.t_rp) - 6'd1;
              wa.st    = BS_PRE_WAIT;
            end
          end
          BS_PRE_WAIT: begin
            if (td == 6'd0) begin
              wa.st   = BS_PRECHARGED;
              wa.ov   = 1'b0;
              wa.orow = 16'd0;
            end
          end
          BS_ACT: begin
            if (!act_block && bus == '0) begin
              iss      = CMD_ACT;
              iss_rc   = rrow;
              wa.st    = BS_ACT_WAIT;
              wa.timer = eff6(cfg.t_rcd) - 6'd1;
            end
          end
          BS_ACT_WAIT: begin
            if (td == 6'd0) begin
              wa.ov   = 1'b1;
              wa.orow = rrow;
              wa.st   = BS_ACTIVATED;
            end
          end
          BS_RD: begin
            if (!rd_block && bus == '0) begin
              iss      = CMD_RD;
              iss_rc   = {6'd0, rcol};
              wa.st    = BS_RD_WAIT;
              wa.timer = cas;
            end
          end
          BS_WR: begin
            if (!wr_block && bus == '0) begin
              iss      = CMD_WR;
              iss_rc   = {6'd0, rcol};
              wa.st    = BS_WR_WAIT;
              wa.timer = cwd;
            end
          end
          BS_RD_WAIT, BS_WR_WAIT: begin
            if (td == 6'd0 && bus == '0) begin
              wa.st    = BS_BURST;
              wa.timer = 6'(bur) - 6'd1;
              burst_go = 1'b1;
            end
          end
          BS_BURST: begin
            if (td == 6'd0) begin
              wa.st     = BS_ACTIVATED;
              burst_end = 1'b1;
              we_row    = 1'b1;
              we_col    = 1'b1;
              wrow      = 16'd0;
              wcol      = 10'd0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Time-since counters zero on issue, bus timer loads on issue or burst; all step at the last bank
  always_comb begin
    for (int g = 0; g < BANK_GROUPS; g++) begin
      since_act_next[g] = (iss == CMD_ACT && step_bg == 2'(g)) ? 8'd0 : since_act[g];
      since_rd_next[g]  = (iss == CMD_RD && step_bg == 2'(g)) ? 8'd0 : since_rd[g];
      since_wr_next[g]  = (iss == CMD_WR && step_bg == 2'(g)) ? 8'd0 : since_wr[g];
      if (last_bank) begin
        if (since_act_next[g] != SAT) since_act_next[g] = since_act_next[g] + 8'd1;
        if (since_rd_next[g] != SAT)  since_rd_next[g]  = since_rd_next[g] + 8'd1;
        if (since_wr_next[g] != SAT)  since_wr_next[g]  = since_wr_next[g] + 8'd1;
      end
    end
    for (int b = 0; b < BANKS_PER_GROUP; b++) begin
      since_bwr_next[b] = (iss == CMD_WR && step_bk == 2'(b)) ? 8'd0 : since_bwr[b];
      if (last_bank && since_bwr_next[b] != SAT) since_bwr_next[b] = since_bwr_next[b] + 8'd1;
    end
    if (iss != CMD_NONE) bus_next = BUS_W'(1);
    else if (burst_go)   bus_next = BUS_W'(bur);
    else                 bus_next = bus;
    if (last_bank && bus_next != '0) bus_next = bus_next - BUS_W'(1);
  end

  // Queue control
  always_comb begin
    qctl          = '0;
    qctl.enq_ent  = item;
    qctl.idx      = scan[QIDX_W-1:0];
    case (state)
      E_IDLE: qctl.enq = start && op && enq_ok;
      E_TRIG: qctl.set_busy = scan_in && !q_ent.busy && !busy_vec[e_bank];
      E_REL: begin
        if (rel_pend) begin
          if (!cfg.bank_parallel) begin
            qctl.idx = '0;
            qctl.rem = (q_count != '0);
          end else begin
            qctl.rem = scan_in && q_ent.busy && q_ent.bg == rel_bg && q_ent.bk == rel_bk;
          end
        end
      end
      default: ;
    endcase
  end

  assign res_valid   = (state == E_FIN);
  assign res.cmd     = r_cmd;
  assign res.bg      = r_bg;
  assign res.bk      = r_bk;
  assign res.rc      = r_rc;
  assign res.acc     = r_acc;
  assign res.full    = (q_count == QCNT_W'(QUEUE_DEPTH));
  assign res.settled = (unsettled == '0);

  // Synchronous memories with a registered read
  always_ff @(posedge clk) begin
    rd_a     <= mem_a[raddr];
    rd_row   <= mem_row[raddr];
    rd_col   <= mem_col[raddr];
    rd_av    <= a_valid[raddr];
    rd_rv    <= row_valid[raddr];
    rd_cv    <= col_valid[raddr];
    cur_bank <= raddr;
    if (we_a)   mem_a[cur_bank]  <= wa;
    if (we_row) mem_row[wb_addr] <= wrow;
    if (we_col) mem_col[wb_addr] <= wcol;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= E_IDLE;
      scan        <= '0;
      step_bg     <= '0;
      step_bk     <= '0;
      a_valid     <= '0;
      row_valid   <= '0;
      col_valid   <= '0;
      busy_vec    <= '0;
      unsettled   <= '0;
      for (int g = 0; g < BANK_GROUPS; g++) begin
        since_act[g] <= SAT;
        since_rd[g]  <= SAT;
        since_wr[g]  <= SAT;
      end
      for (int b = 0; b < BANKS_PER_GROUP; b++) since_bwr[b] <= SAT;
      last_cmd    <= CMD_NONE;
      last_act_bg <= '0;
      last_rd_bg  <= '0;
      last_wr_bg  <= '0;
      last_wr_bk  <= '0;
      bus         <= '0;
      rel_pend    <= 1'b0;
      rel_bg      <= '0;
      rel_bk      <= '0;
      r_cmd       <= CMD_NONE;
      r_bg        <= '0;
      r_bk        <= '0;
      r_rc        <= '0;
      r_acc       <= 1'b0;
    end else begin
      if (we_a)   a_valid[cur_bank]  <= 1'b1;
      if (we_row) row_valid[wb_addr] <= 1'b1;
      if (we_col) col_valid[wb_addr] <= 1'b1;
      case (state)
        E_IDLE: begin
          if (start) begin
            r_cmd    <= CMD_NONE;
            r_bg     <= '0;
            r_bk     <= '0;
            r_rc     <= '0;
            r_acc    <= op && enq_ok;
            rel_pend <= 1'b0;
            scan     <= '0;
            step_bg  <= '0;
            step_bk  <= '0;
            if (op)                     state <= E_FIN;
            else if (cfg.bank_parallel) state <= E_TRIG;
            else if (q_count != '0)     state <= E_KADDR;
            else                        state <= E_SADDR;
          end
        end
        E_TRIG: begin
          if (scan_in) begin
            if (qctl.set_busy) busy_vec[e_bank] <= 1'b1;
            scan <= scan + QCNT_W'(1);
          end else begin
            scan  <= '0;
            state <= E_KADDR;
          end
        end
        E_KADDR: begin
          // head mode kicks the head only; bank-parallel kicks every busy entry
          if (scan_in && (!cfg.bank_parallel || q_ent.busy)) state <= E_KUPD;
          else if (scan_in) scan <= scan + QCNT_W'(1);
          else state <= E_SADDR;
        end
        E_KUPD: begin
          unsettled[cur_bank] <= !(wa.st == BS_PRECHARGED || wa.st == BS_ACTIVATED);
          scan <= scan + QCNT_W'(1);
          if (!cfg.bank_parallel) state <= E_SADDR;
          else                    state <= E_KADDR;
        end
        E_SADDR: state <= E_SUPD;
        E_SUPD: begin
          unsettled[cur_bank] <= !(wa.st == BS_PRECHARGED || wa.st == BS_ACTIVATED);
          if (burst_end) busy_vec[cur_bank] <= 1'b0;
          since_act <= since_act_next;
          since_rd  <= since_rd_next;
          since_wr  <= since_wr_next;
          since_bwr <= since_bwr_next;
          bus       <= bus_next;
          if (iss != CMD_NONE) begin
            r_cmd <= iss;
            r_bg  <= step_bg;
            r_bk  <= step_bk;
            r_rc  <= iss_rc;
          end
          case (iss)
            CMD_ACT: begin
              last_act_bg <= step_bg;
              last_cmd    <= CMD_ACT;
            end
            CMD_RD: begin
              last_rd_bg <= step_bg;
              last_cmd   <= CMD_RD;
              rel_pend   <= 1'b1;
              rel_bg     <= step_bg;
              rel_bk     <= step_bk;
            end
            CMD_WR: begin
              last_wr_bg <= step_bg;
              last_wr_bk <= step_bk;
              last_cmd   <= CMD_WR;
              rel_pend   <= 1'b1;
              rel_bg     <= step_bg;
              rel_bk     <= step_bk;
            end
            default: ;
          endcase
          if (last_bank) begin
            scan  <= '0;
            state <= E_REL;
          end else begin
            state <= E_SADDR;
            if (step_bk == 2'(BANKS_PER_GROUP - 1)) begin
              step_bk <= '0;
              step_bg <= step_bg + 2'd1;
            end else begin
              step_bk <= step_bk + 2'd1;
            end
          end
        end
        E_REL: begin
          if (!rel_pend || !cfg.bank_parallel || qctl.rem || !scan_in) state <= E_FIN;
          else scan <= scan + QCNT_W'(1);
        end
        E_FIN: begin
          if (res_ready) state <= E_IDLE;
        end
        default: state <= E_IDLE;
      endcase
    end
  end

  a_issue_bus_free: assert property (@(posedge clk) disable iff (rst)
    (state == E_SUPD && iss != CMD_NONE) |-> (bus == '0))
    else $error("command issued while data bus busy");

  a_queue_ops_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({qctl.enq, qctl.set_busy, qctl.rem}))
    else $error("more than one queue operation in a cycle");

  a_column_release: assert property (@(posedge clk) disable iff (rst)
    (state == E_SUPD && (iss == CMD_RD || iss == CMD_WR)) |=> rel_pend)
    else $error("column command without queue release");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

endmodule

>>> src/dram_bank_command_scheduler.sv
// Top level of the DRAM bank command scheduler: streams, APB and result register.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tuser=op, s_tdata=request fields
//  m_*      out  m_tvalid/m_tready  m_tdata=command and status fields
//  apb      in   psel/penable       8 registers at byte address 4*i
//
// The input is ready only while the engine is idle, so a word is not taken
// until the result of the last one has gone to the result register. A tick
// word steps each bank record in turn through an address state and an update
// state for the read-modify-write of the bank memory, after a kick of the
// head request in head mode. Bank-parallel mode adds the queue trigger, kick
// and release scans.
// Reset is synchronous; all banks come up precharged with no row open.
// The result register frees the engine; a stalled output holds the next result.
module dram_bank_command_scheduler import dbcs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // req_bank_group, req_bank, req_row, req_col, req_is_write
  input  logic        s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // cmd, cmd_bank_group, cmd_bank, cmd_row_or_column,
                                 // accepted, queue_full, all_banks_settled
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t              cfg;
  q_ctl_t            qctl;
  qent_t             q_ent, item;
  logic [QCNT_W-1:0] q_count;
  logic              idle, start, res_valid, res_ready;
  res_t              res;

  assign s_tready  = idle;
  assign start     = s_tvalid & s_tready;
  assign res_ready = !m_tvalid || m_tready;

  assign item.bg   = s_tdata[1:0];
  assign item.bk   = s_tdata[3:2];
  assign item.row  = s_tdata[19:4];
  assign item.col  = s_tdata[29:20];
  assign item.wr   = s_tdata[30];
  assign item.busy = 1'b0;

  dbcs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dbcs_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .ctl    (qctl),
    .rd_ent (q_ent),
    .count  (q_count)
  );

  dbcs_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (start),
    .op        (s_tuser),
    .item      (item),
    .idle      (idle),
    .qctl      (qctl),
    .q_ent     (q_ent),
    .q_count   (q_count),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {6'd0, res.settled, res.full, res.acc, res.rc, res.bk, res.bg, res.cmd};
    end
  end

endmodule

>>> tb/dram_bank_command_scheduler_tb.sv
// Self-checking stream testbench for the DRAM bank command scheduler.
`timescale 1ns / 100ps

module dram_bank_command_scheduler_tb import dbcs_pkg::*;;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // req_bank_group, req_bank, req_row, req_col, req_is_write
  logic        s_tuser;   // op
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // cmd, cmd_bank_group, cmd_bank, cmd_row_or_column,
                          // accepted, queue_full, all_banks_settled
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  dram_bank_command_scheduler dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  typedef struct {
    logic        op;
    logic [31:0] data;
  } word_t;

  word_t pending_words[$];
  res_t  expected_cmds[$];
  int    idle_pct;
  int    stall_pct;
  logic  took;
  int    mismatches;
  int    n_results;
  int    n_issued;

  // Scheduler shadow state
  logic       par_mode;
  logic [5:0] rcd, rp, cas, cwd, ccd_l, ccd_s;
  logic [3:0] burst;
  qent_t      req_q[QUEUE_DEPTH];
  int         q_cnt;
  bank_st_t   b_st[NBANKS];
  int         b_tmr[NBANKS];
  logic [15:0] b_orow[NBANKS], b_prow[NBANKS];
  logic [9:0] b_pcol[NBANKS];
  logic       b_ov[NBANKS], b_busy[NBANKS];
  int         since_act[BANK_GROUPS], since_rd[BANK_GROUPS], since_wr[BANK_GROUPS];
  int         since_bwr[BANKS_PER_GROUP];
  cmd_t       last_cmd;
  int         last_act_bg, last_rd_bg, last_wr_bg, last_wr_bk;
  int         bus_tmr;
  res_t       cur;

  function automatic int nz(int v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic void sched_reset();
    par_mode = 0; rcd = 24; rp = 24; cas = 24; cwd = 20; burst = 4; ccd_l = 8; ccd_s = 4;
    q_cnt = 0;
    for (int i = 0; i < NBANKS; i++) begin
      b_st[i] = BS_PRECHARGED; b_tmr[i] = 0; b_orow[i] = 0; b_prow[i] = 0;
      b_pcol[i] = 0; b_ov[i] = 0; b_busy[i] = 0;
    end
    for (int i = 0; i < BANK_GROUPS; i++) begin
      since_act[i] = 255; since_rd[i] = 255; since_wr[i] = 255;
    end
    for (int i = 0; i < BANKS_PER_GROUP; i++) since_bwr[i] = 255;
    last_cmd = CMD_NONE; last_act_bg = 0; last_rd_bg = 0; last_wr_bg = 0; last_wr_bk = 0;
    bus_tmr = 0;
  endfunction

  function automatic void put_cmd(cmd_t c, int bg, int bk, logic [15:0] rc);
    cur.cmd = c; cur.bg = bg[1:0]; cur.bk = bk[1:0]; cur.rc = rc;
    bus_tmr = 1;
  endfunction

  function automatic void q_drop(int p);
    for (int i = p; i + 1 < q_cnt; i++) req_q[i] = req_q[i + 1];
    q_cnt--;
  endfunction

  function automatic void q_free(int bg, int bk);
    if (q_cnt == 0) return;
    if (!par_mode) begin
      q_drop(0);
      return;
    end
    for (int i = 0; i < q_cnt; i++)
      if (req_q[i].busy && req_q[i].bg == bg && req_q[i].bk == bk) begin
        q_drop(i);
        return;
      end
  endfunction

  function automatic void start_bank(int qi, logic load);
    int k;
    k = req_q[qi].bg * BANKS_PER_GROUP + req_q[qi].bk;
    if (b_st[k] != BS_ACTIVATED && b_st[k] != BS_PRECHARGED) return;
    if (b_ov[k] && req_q[qi].row == b_orow[k]) begin
      if (load) b_pcol[k] = req_q[qi].col;
      b_st[k] = req_q[qi].wr ? BS_WR : BS_RD;
    end else if (!b_ov[k]) begin
      if (load) b_prow[k] = req_q[qi].row;
      b_st[k] = BS_ACT;
    end else begin
      b_st[k] = BS_PRE;
    end
  endfunction

  function automatic void advance_bank(int bg, int b);
    int k, wd, bl;
    k = bg * BANKS_PER_GROUP + b;
    wd = nz(cwd);
    bl = nz(burst);
    if (b_tmr[k] != 0) b_tmr[k]--;
    case (b_st[k])
      BS_PRE: begin
        if (last_cmd == CMD_RD && since_rd[last_rd_bg] < T_RTP) return;
        if (last_cmd == CMD_WR && last_wr_bk == b && last_wr_bg == bg &&
            since_bwr[b] <= wd + bl - 1 + T_WR) return;
        if (bus_tmr == 0) begin
          put_cmd(CMD_PRE, bg, b, 0);
          b_tmr[k] = nz(rp) - 1;
          b_st[k] = BS_PRE_WAIT;
        end
      end
      BS_PRE_WAIT: begin
        if (b_tmr[k] == 0) begin
          b_st[k] = BS_PRECHARGED; b_ov[k] = 0; b_orow[k] = 0;
        end
      end
      BS_ACT: begin
        if (last_act_bg == bg && since_act[bg] < T_RRD_L) return;
        if (last_act_bg != bg && since_act[last_act_bg] < T_RRD_S) return;
        if (bus_tmr == 0) begin
          put_cmd(CMD_ACT, bg, b, b_prow[k]);
          b_st[k] = BS_ACT_WAIT;
          b_tmr[k] = nz(rcd) - 1;
          last_act_bg = bg; since_act[bg] = 0; last_cmd = CMD_ACT;
        end
      end
      BS_ACT_WAIT: begin
        if (b_tmr[k] == 0) begin
          b_ov[k] = 1; b_orow[k] = b_prow[k]; b_st[k] = BS_ACTIVATED;
        end
      end
      BS_RD: begin
        if (last_cmd == CMD_RD) begin
          if (last_rd_bg == bg && since_rd[bg] < nz(ccd_l)) return;
          if (last_rd_bg != bg && since_rd[last_rd_bg] < nz(ccd_s)) return;
        end else if (last_cmd == CMD_WR) begin
          if (last_wr_bg == bg && since_wr[bg] <= wd + bl - 1 + T_WTR_L) return;
          if (last_wr_bg != bg && since_wr[last_wr_bg] <= wd + bl - 1 + T_WTR_S) return;
        end
        if (bus_tmr == 0) begin
          put_cmd(CMD_RD, bg, b, {6'd0, b_pcol[k]});
          b_st[k] = BS_RD_WAIT;
          b_tmr[k] = nz(cas);
          last_rd_bg = bg; last_cmd = CMD_RD; since_rd[bg] = 0;
          q_free(bg, b);
        end
      end
      BS_WR: begin
        if (last_cmd == CMD_RD) begin
          if (since_rd[last_rd_bg] < nz(cas) + bl - wd + 2) return;
        end else if (last_cmd == CMD_WR) begin
          if (last_wr_bg == bg && since_wr[bg] < nz(ccd_l)) return;
          if (last_wr_bg != bg && since_wr[last_wr_bg] < nz(ccd_s)) return;
        end
        if (bus_tmr == 0) begin
          put_cmd(CMD_WR, bg, b, {6'd0, b_pcol[k]});
          b_st[k] = BS_WR_WAIT;
          b_tmr[k] = wd;
          last_wr_bg = bg; last_wr_bk = b; last_cmd = CMD_WR;
          since_wr[bg] = 0; since_bwr[b] = 0;
          q_free(bg, b);
        end
      end
      BS_RD_WAIT, BS_WR_WAIT: begin
        if (b_tmr[k] == 0 && bus_tmr == 0) begin
          b_st[k] = BS_BURST;
          b_tmr[k] = bl - 1;
          bus_tmr = bl;
        end
      end
      BS_BURST: begin
        if (b_tmr[k] == 0) begin
          b_st[k] = BS_ACTIVATED; b_busy[k] = 0; b_prow[k] = 0; b_pcol[k] = 0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic res_t sched_step(logic op, logic [31:0] d);
    int k;
    cur = '0;
    cur.cmd = CMD_NONE;
    if (op) begin
      if (q_cnt < QUEUE_DEPTH) begin
        req_q[q_cnt] = '{bg: d[1:0], bk: d[3:2], row: d[19:4], col: d[29:20],
                         wr: d[30], busy: 1'b0};
        q_cnt++;
        cur.acc = 1;
      end
    end else begin
      if (!par_mode) begin
        if (q_cnt != 0) start_bank(0, 1);
      end else begin
        for (int i = 0; i < q_cnt; i++) begin
          k = req_q[i].bg * BANKS_PER_GROUP + req_q[i].bk;
          if (!req_q[i].busy && !b_busy[k]) begin
            req_q[i].busy = 1; b_busy[k] = 1;
            b_prow[k] = req_q[i].row; b_pcol[k] = req_q[i].col;
          end
        end
        for (int i = 0; i < q_cnt; i++)
          if (req_q[i].busy) start_bank(i, 0);
      end
      for (int g = 0; g < BANK_GROUPS; g++)
        for (int b = 0; b < BANKS_PER_GROUP; b++) advance_bank(g, b);
      if (bus_tmr != 0) bus_tmr--;
      for (int i = 0; i < BANK_GROUPS; i++) begin
        if (since_act[i] < 255) since_act[i]++;
        if (since_rd[i] < 255) since_rd[i]++;
        if (since_wr[i] < 255) since_wr[i]++;
      end
      for (int i = 0; i < BANKS_PER_GROUP; i++)
        if (since_bwr[i] < 255) since_bwr[i]++;
    end
    cur.full = (q_cnt >= QUEUE_DEPTH);
    cur.settled = 1;
    for (int i = 0; i < NBANKS; i++)
      if (b_st[i] != BS_PRECHARGED && b_st[i] != BS_ACTIVATED) cur.settled = 0;
    return cur;
  endfunction

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Source side: hold a word until taken, then pick the next one or idle
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || took) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
          s_tuser  <= pending_words[0].op;
          s_tdata  <= pending_words[0].data;
          s_tvalid <= 1'b1;
          void'(pending_words.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    res_t want, got;
    if (rst) begin
      took <= 1'b0;
    end else begin
      took <= s_tvalid && s_tready;
      if (s_tvalid && s_tready)
        expected_cmds.insert(expected_cmds.size(), sched_step(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        got = '{cmd: cmd_t'(m_tdata[2:0]), bg: m_tdata[4:3], bk: m_tdata[6:5],
                rc: m_tdata[22:7], acc: m_tdata[23], full: m_tdata[24],
                settled: m_tdata[25]};
        n_results++;
        if (expected_cmds.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", m_tdata);
        end else begin
          want = expected_cmds.pop_front();
          if (want.cmd != CMD_NONE) n_issued++;
          if (got.cmd != want.cmd || got.bg != want.bg || got.bk != want.bk ||
              got.rc != want.rc || got.acc != want.acc || got.full != want.full ||
              got.settled != want.settled) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("word %0d: expected cmd %0d bg %0d bk %0d rc %h acc %b full %b set %b",
                       n_results, want.cmd, want.bg, want.bk, want.rc, want.acc, want.full,
                       want.settled);
              $display("  got cmd %0d bg %0d bk %0d rc %h acc %b full %b set %b",
                       got.cmd, got.bg, got.bk, got.rc, got.acc, got.full, got.settled);
            end
          end
        end
      end
    end
  end

  task automatic reg_write(reg_idx_t idx, int val);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= 5'(int'(idx) * 4); pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_BANK_PARALLEL: par_mode = val[0];
      REG_T_RCD:         rcd = val[5:0];
      REG_T_RP:          rp = val[5:0];
      REG_T_CAS:         cas = val[5:0];
      REG_T_CWD:         cwd = val[5:0];
      REG_T_BURST:       burst = val[3:0];
      REG_T_CCD_LONG:    ccd_l = val[5:0];
      REG_T_CCD_SHORT:   ccd_s = val[5:0];
      default: ;
    endcase
  endtask

  task automatic set_timing(int bp, int t_rcd, int t_rp, int t_cas, int t_cwd, int t_bl,
                            int t_ccdl, int t_ccds);
    reg_write(REG_BANK_PARALLEL, bp);
    reg_write(REG_T_RCD, t_rcd);
    reg_write(REG_T_RP, t_rp);
    reg_write(REG_T_CAS, t_cas);
    reg_write(REG_T_CWD, t_cwd);
    reg_write(REG_T_BURST, t_bl);
    reg_write(REG_T_CCD_LONG, t_ccdl);
    reg_write(REG_T_CCD_SHORT, t_ccds);
  endtask

  task automatic add_req(int bg, int bk, int row, int col, int wr);
    word_t w;
    w.op = 1;
    w.data = {1'b0, wr[0], col[9:0], row[15:0], bk[1:0], bg[1:0]};
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic add_ticks(int n);
    word_t w;
    w.op = 0;
    w.data = $urandom;
    for (int i = 0; i < n; i++) pending_words.insert(pending_words.size(), w);
  endtask

  task automatic add_random(int n);
    int row;
    word_t w;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 25) begin
        case ($urandom_range(3))
          0: row = 0;
          1: row = 1;
          2: row = 16'hFFFF;
          default: row = $urandom_range(65535);
        endcase
        add_req($urandom_range(3), $urandom_range(1) ? $urandom_range(3) : 0, row,
                $urandom_range(1023), $urandom_range(1));
      end else begin
        w.op = 0;
        w.data = $urandom;   // payload ignored on ticks
        pending_words.insert(pending_words.size(), w);
      end
    end
  endtask

  task automatic drain();
    wait (pending_words.size() == 0 && !s_tvalid && expected_cmds.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    s_tvalid = 0; s_tdata = 0; s_tuser = 0; m_tready = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    idle_pct = 0; stall_pct = 0;
    mismatches = 0; n_results = 0; n_issued = 0;
    sched_reset();
    rst = 1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: field extremes, row hit, row conflict, then overfill the queue
    add_req(3, 3, 16'hFFFF, 1023, 1);
    add_req(0, 0, 0, 0, 0);
    add_ticks(3);
    add_req(3, 3, 16'hFFFF, 5, 0);
    add_req(3, 3, 16'h1234, 7, 1);
    for (int i = 0; i < 14; i++) add_req(i % 4, i / 4, 16'hFFFF, 1023, 1);
    add_ticks(4);
    add_random(200);
    drain();

    set_timing(1, 1, 1, 1, 1, 1, 1, 1);
    idle_pct = 76;
    add_random(230);
    drain();

    set_timing(1, 63, 63, 63, 63, 15, 63, 63);
    idle_pct = 0; stall_pct = 76;
    add_random(230);
    drain();

    set_timing(0, 0, 0, 0, 0, 0, 0, 0);
    idle_pct = 25; stall_pct = 25;
    add_random(120);
    drain();

    set_timing(1, 3, 5, 9, 2, 2, 6, 2);
    add_random(120);
    drain();
    repeat (100) @(posedge clk);

    $display("Checked %0d result words, %0d with an issued command, over head and bank-parallel",
             n_results, n_issued);
    $display("modes at minimum, maximum, zero and mixed timings; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
